// ===== rtl/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types, constants and the microcode program of the next-fit allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

   // port field widths
   localparam int IDX_BITS       = 6;
   localparam int PORT_SIZE_BITS = 16;
   localparam int DATA_BITS      = 24;
   localparam int CFG_BITS       = 7;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CFG_BITS-1:0] BLOCK_COUNT_RESET = 7'd64;

   // register index, taken from the word address bit of paddr
   localparam logic REG_BLOCK_COUNT = 1'b0;

   // request kinds
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // microprogram steps
   typedef enum logic [2:0] {
      ST_FETCH,
      ST_DISPATCH,
      ST_TEST,
      ST_STEP,
      ST_HIT,
      ST_MISS,
      ST_LOAD
   } step_type;

   // branch conditions
   typedef enum logic [2:0] {
      CND_NO_REQ,
      CND_IS_LOAD,
      CND_FIT,
      CND_MORE,
      CND_OUT_BUSY
   } cond_type;

   // datapath operations
   typedef enum logic [2:0] {
      ACT_LATCH,
      ACT_INIT,
      ACT_NONE,
      ACT_ADV,
      ACT_EMIT_HIT,
      ACT_EMIT_MISS,
      ACT_EMIT_LOAD
   } act_type;

   // one control word: branch to target when cond holds, else to next_step
   typedef struct packed {
      cond_type cond;
      step_type target;
      step_type next_step;
      act_type  act;
   } uword_type;

   // decoded strobes from sequencer to datapath
   typedef struct packed {
      logic take;
      logic latch;
      logic init;
      logic adv;
      logic emit_hit;
      logic emit_miss;
      logic emit_load;
   } ctrl_type;

   // condition flags from datapath to sequencer
   typedef struct packed {
      logic req_valid;
      logic is_load;
      logic fit;
      logic more;
      logic out_busy;
   } status_type;

   // control store
   function automatic uword_type ucode_rom(input step_type s);
      uword_type w;
      case (s)
         ST_FETCH:    w = '{CND_NO_REQ,   ST_FETCH, ST_DISPATCH, ACT_LATCH};
         ST_DISPATCH: w = '{CND_IS_LOAD,  ST_LOAD,  ST_TEST,     ACT_INIT};
         ST_TEST:     w = '{CND_FIT,      ST_HIT,   ST_STEP,     ACT_NONE};
         ST_STEP:     w = '{CND_MORE,     ST_TEST,  ST_MISS,     ACT_ADV};
         ST_HIT:      w = '{CND_OUT_BUSY, ST_HIT,   ST_FETCH,    ACT_EMIT_HIT};
         ST_MISS:     w = '{CND_OUT_BUSY, ST_MISS,  ST_FETCH,    ACT_EMIT_MISS};
         ST_LOAD:     w = '{CND_OUT_BUSY, ST_LOAD,  ST_FETCH,    ACT_EMIT_LOAD};
         default:     w = '{CND_NO_REQ,   ST_FETCH, ST_FETCH,    ACT_NONE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/nfba_ram.sv =====
// ----------------------------------------------------------------------------
// nfba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nfba_seq.sv =====
// ----------------------------------------------------------------------------
// nfba_seq
// Micro-sequencer: step counter, control store lookup and branch selection.
// ----------------------------------------------------------------------------
module nfba_seq
   import nfba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type  upc_ff;
   step_type  upc_in;
   uword_type uw;
   logic      cond_true;

   // fetch control word and evaluate its branch condition
   always_comb begin
      uw = ucode_rom(upc_ff);
      case (uw.cond)
         CND_NO_REQ:   cond_true = !status.req_valid;
         CND_IS_LOAD:  cond_true = status.is_load;
         CND_FIT:      cond_true = status.fit;
         CND_MORE:     cond_true = status.more;
         CND_OUT_BUSY: cond_true = status.out_busy;
         default:      cond_true = 1'b0;
      endcase
      upc_in = cond_true ? uw.target : uw.next_step;
   end

   // decode operation, result steps fire only once the output register frees
   always_comb begin
      ctrl = '0;
      ctrl.take = (upc_ff == ST_FETCH);
      case (uw.act)
         ACT_LATCH:     ctrl.latch     = status.req_valid;
         ACT_INIT:      ctrl.init      = 1'b1;
         ACT_ADV:       ctrl.adv       = 1'b1;
         ACT_EMIT_HIT:  ctrl.emit_hit  = !status.out_busy;
         ACT_EMIT_MISS: ctrl.emit_miss = !status.out_busy;
         ACT_EMIT_LOAD: ctrl.emit_load = !status.out_busy;
         default:       ;
      endcase
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/nfba_dpath.sv =====
// ----------------------------------------------------------------------------
// nfba_dpath
// Scan datapath: request latch, roving pointer, size table and result register.
// ----------------------------------------------------------------------------
module nfba_dpath
   import nfba_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_type                  ctrl,
   output status_type                status,
   input  logic [CFG_BITS-1:0]       block_count,
   input  logic                      req_op,
   input  logic [IDX_BITS-1:0]       req_index,
   input  logic [PORT_SIZE_BITS-1:0] req_size,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_granted,
   output logic [IDX_BITS-1:0]       rsp_index,
   output logic [PORT_SIZE_BITS-1:0] rsp_remain
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   // latched request
   logic                      op_ff;
   logic [IDX_BITS-1:0]       idx_ff;
   logic [SIZE_BITS-1:0]      size_ff;
   // scan state
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [IDX_BITS-1:0]       rover_ff, rover_in;
   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_granted_ff, rsp_granted_in;
   logic [IDX_BITS-1:0]       rsp_index_ff, rsp_index_in;
   logic [PORT_SIZE_BITS-1:0] rsp_remain_ff, rsp_remain_in;

   logic [CNT_W-1:0]          act_n;
   logic [IDX_W-1:0]          start_ptr;
   logic [IDX_W-1:0]          ptr_wrap;
   logic [SIZE_BITS-1:0]      rd_data;
   logic [SIZE_BITS-1:0]      diff;
   logic                      in_range;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [SIZE_BITS-1:0]      wr_data;

   // clamp block count to one .. table depth, pick the scan start
   always_comb begin
      if (block_count == '0) begin
         act_n = CNT_W'(1);
      end else if (32'(block_count) > 32'(MAX_BLOCKS)) begin
         act_n = CNT_W'(MAX_BLOCKS);
      end else begin
         act_n = CNT_W'(block_count);
      end
      start_ptr = (32'(rover_ff) >= 32'(act_n)) ? '0 : IDX_W'(rover_ff);
   end

   // pointer advance with wrap at the block count
   assign ptr_wrap = ((CNT_W'(ptr_ff) + CNT_W'(1)) == n_ff) ? '0 : ptr_ff + IDX_W'(1);

   assign diff     = rd_data - size_ff;
   assign in_range = 32'(idx_ff) < 32'(MAX_BLOCKS);

   // branch flags
   always_comb begin
      status.req_valid = 1'b0;
      status.is_load   = (op_ff == OP_LOAD);
      status.fit       = rd_data >= size_ff;
      status.more      = (k_ff + CNT_W'(1)) < n_ff;
      status.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   // scan registers
   always_comb begin
      n_in     = n_ff;
      ptr_in   = ptr_ff;
      k_in     = k_ff;
      rover_in = rover_ff;
      if (ctrl.init) begin
         n_in   = act_n;
         ptr_in = start_ptr;
         k_in   = '0;
      end
      if (ctrl.adv) begin
         ptr_in = ptr_wrap;
         k_in   = k_ff + CNT_W'(1);
      end
      if (ctrl.emit_hit || ctrl.emit_miss) begin
         rover_in = IDX_BITS'(ptr_ff);
      end
   end

   // table write: reduced entry on a hit, new size on an in-range load
   always_comb begin
      wr_en   = ctrl.emit_hit || (ctrl.emit_load && in_range);
      wr_addr = ctrl.emit_hit ? ptr_ff : IDX_W'(idx_ff);
      wr_data = ctrl.emit_hit ? diff : size_ff;
   end

   // result register, free again once taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_remain_in  = rsp_remain_ff;
      if (ctrl.emit_hit) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = 1'b1;
         rsp_index_in   = IDX_BITS'(ptr_ff);
         rsp_remain_in  = PORT_SIZE_BITS'(diff);
      end else if (ctrl.emit_miss) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = 1'b0;
         rsp_index_in   = IDX_BITS'(ptr_ff);
         rsp_remain_in  = '0;
      end else if (ctrl.emit_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = in_range;
         rsp_index_in   = idx_ff;
         rsp_remain_in  = in_range ? PORT_SIZE_BITS'(size_ff) : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         op_ff   <= req_op;
         idx_ff  <= req_index;
         size_ff <= SIZE_BITS'(req_size);
      end
      n_ff           <= n_in;
      ptr_ff         <= ptr_in;
      k_ff           <= k_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_remain_ff  <= rsp_remain_in;
   end

   // size table, read address follows the next pointer so data matches the registered pointer
   nfba_ram #(
      .WIDTH(SIZE_BITS),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(ptr_in),
      .rd_data(rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_remain  = rsp_remain_ff;

   // scan never walks past the in-use entries
   a_ptr_in_use: assert property (@(posedge clock) disable iff (reset)
      ctrl.adv |-> (CNT_W'(ptr_ff) < n_ff) && (k_ff < n_ff))
      else $error("scan pointer or count beyond block count");

   // a hit only reduces an entry that holds enough
   a_hit_fits: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_hit |-> rd_data >= size_ff)
      else $error("allocation from an entry that is too small");

   // a result is only loaded into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit_hit || ctrl.emit_miss || ctrl.emit_load) |->
         !(rsp_valid_ff && !rsp_ready))
      else $error("result overwritten before it was taken");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit_hit || ctrl.emit_miss || ctrl.emit_load) |=> rsp_valid_ff)
      else $error("result not presented after emit");

endmodule

// ===== rtl/next_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over a table of free block sizes, with a roving pointer.
// ----------------------------------------------------------------------------
// A load goes from dispatch straight to its result step; an allocation tests
// entries from the roving pointer until one fits or all n entries are scanned
// (n = clamped block count); each skipped entry costs a test and a pointer step.
// The result step waits while the output register holds an untaken result; the
// next request can be accepted in the cycle after a result is loaded. Reset clears the
// pointer, the sequencer and the output valid, sets block count to 64; no table clear.
// ----------------------------------------------------------------------------
module next_fit_block_allocator
   import nfba_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_BITS-1:0]     req_tdata,   // block_index[5:0], size_value[21:6]
   input  logic                     req_tuser,   // op[0]
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [DATA_BITS-1:0]     rsp_tdata,   // chosen_index[5:0], remaining_size[21:6]
   output logic                     rsp_tuser,   // granted[0]
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [CFG_BITS-1:0]       block_count_ff, block_count_in;
   logic                      csr_wr;
   ctrl_type                  ctrl;
   status_type                dp_status;
   status_type                status;
   logic                      rsp_granted;
   logic [IDX_BITS-1:0]       rsp_index;
   logic [PORT_SIZE_BITS-1:0] rsp_remain;

   // register write and readback
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      block_count_in = block_count_ff;
      if (csr_wr && (csr_paddr[2] == REG_BLOCK_COUNT)) begin
         block_count_in = csr_pwdata[CFG_BITS-1:0];
      end
      csr_prdata = (csr_paddr[2] == REG_BLOCK_COUNT) ?
                   CSR_DATA_BITS'(block_count_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   // request valid joins the datapath flags
   always_comb begin
      status           = dp_status;
      status.req_valid = req_tvalid;
   end

   assign req_tready = ctrl.take;

   nfba_seq u_seq (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctrl  (ctrl)
   );

   nfba_dpath #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (dp_status),
      .block_count(block_count_ff),
      .req_op     (req_tuser),
      .req_index  (req_tdata[IDX_BITS-1:0]),
      .req_size   (req_tdata[IDX_BITS+PORT_SIZE_BITS-1:IDX_BITS]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_granted(rsp_granted),
      .rsp_index  (rsp_index),
      .rsp_remain (rsp_remain)
   );

   // result packing
   assign rsp_tuser = rsp_granted;
   assign rsp_tdata = {{(DATA_BITS - IDX_BITS - PORT_SIZE_BITS){1'b0}}, rsp_remain, rsp_index};

endmodule

// ===== tb/sv/next_fit_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_allocator_tb
// Self-checking testbench for the next-fit block allocator. A scoreboard keeps
// its own copy of the free-size table, the roving pointer and the block count,
// predicts the response to every accepted request and compares each accepted
// response field by field. Directed requests cover size extremes, exact fits,
// misses, clamped block counts and a pointer left beyond the block count.
// Random phases follow, with several block counts and idle patterns.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_tb;
   import nfba_pkg::*;

   localparam int TABLE_DEPTH = 64;

   typedef struct packed {
      logic                      granted;
      logic [IDX_BITS-1:0]       chosen_index;
      logic [PORT_SIZE_BITS-1:0] remaining_size;
   } alloc_result_type;

   // predicts allocator responses and checks them in order
   class alloc_scoreboard_type;
      logic [PORT_SIZE_BITS-1:0] free_size [TABLE_DEPTH];
      logic [IDX_BITS-1:0]       rover;
      logic [CFG_BITS-1:0]       block_count;
      alloc_result_type          expected_q[$];
      int                        errors;

      function new();
         rover       = '0;
         block_count = BLOCK_COUNT_RESET;
         errors      = 0;
         foreach (free_size[i]) free_size[i] = '0;
      endfunction

      function void set_count(logic [CFG_BITS-1:0] value);
         block_count = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // update the table for one accepted request and queue its response
      function void note_request(logic op, logic [IDX_BITS-1:0] idx,
                                 logic [PORT_SIZE_BITS-1:0] size);
         alloc_result_type r;
         int               n;
         int               p;
         bit               hit;
         if (op == OP_LOAD) begin
            free_size[idx]   = size;
            r.granted        = 1'b1;
            r.chosen_index   = idx;
            r.remaining_size = size;
         end else begin
            n = (block_count == 0) ? 1 :
                (block_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(block_count);
            p = (rover >= n) ? 0 : int'(rover);
            hit = 1'b0;
            for (int k = 0; k < n && !hit; k++) begin
               if (free_size[p] >= size) begin
                  free_size[p] = free_size[p] - size;
                  hit = 1'b1;
               end else begin
                  p = (p + 1 == n) ? 0 : p + 1;
               end
            end
            rover            = p[IDX_BITS-1:0];
            r.granted        = hit;
            r.chosen_index   = p[IDX_BITS-1:0];
            r.remaining_size = hit ? free_size[p] : '0;
         end
         expected_q.push_back(r);
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected response: granted %0d index %0d remaining %0h",
                   got.granted, got.chosen_index, got.remaining_size);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            errors++;
         end
         if (got.chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d",
                   want.chosen_index, got.chosen_index);
            errors++;
         end
         if (got.remaining_size !== want.remaining_size) begin
            $error("remaining_size: expected %0h, actual %0h",
                   want.remaining_size, got.remaining_size);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_BITS-1:0]     req_tdata = '0;   // block_index[5:0], size_value[21:6]
   logic                     req_tuser = 1'b0; // op[0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]     rsp_tdata;        // chosen_index[5:0], remaining_size[21:6]
   logic                     rsp_tuser;        // granted[0]
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   alloc_scoreboard_type sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;

   next_fit_block_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always #6 clock = ~clock;

   // watchdog
   initial begin
      #15_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response back-pressure, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor both handshakes
   always @(posedge clock) begin
      alloc_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[5:0], req_tdata[21:6]);
         if (rsp_tvalid && rsp_tready) begin
            got.granted        = rsp_tuser;
            got.chosen_index   = rsp_tdata[5:0];
            got.remaining_size = rsp_tdata[21:6];
            sb.check_result(got);
         end
      end
   end

   // offer one request, entered and left at a falling edge
   task automatic send_req(input logic op, input logic [IDX_BITS-1:0] idx,
                           input logic [PORT_SIZE_BITS-1:0] size);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, size, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // random request, mostly allocations against a refilled table
   task automatic send_random();
      logic                      op;
      logic [IDX_BITS-1:0]       idx;
      logic [PORT_SIZE_BITS-1:0] size;
      int                        pick;
      op   = ($urandom_range(99) < 40) ? OP_LOAD : OP_ALLOC;
      idx  = IDX_BITS'($urandom_range(TABLE_DEPTH - 1));
      pick = $urandom_range(9);
      if (op == OP_LOAD) begin
         if (pick < 5)      size = PORT_SIZE_BITS'($urandom);
         else if (pick < 8) size = PORT_SIZE_BITS'(16'hF000 | $urandom_range(16'h0FFF));
         else               size = PORT_SIZE_BITS'($urandom_range(255));
      end else begin
         if (pick < 3)      size = PORT_SIZE_BITS'($urandom_range(255));
         else if (pick < 6) size = PORT_SIZE_BITS'($urandom);
         else if (pick < 8) size = sb.free_size[idx];   // likely exact fit
         else               size = PORT_SIZE_BITS'(16'hFFFF - $urandom_range(3));
      end
      send_req(op, idx, size);
   endtask

   // register write: setup then access phase
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_count(data[CFG_BITS-1:0]);
   endtask

   // stop offering and wait until every predicted response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // new block count once the allocator is idle; upper bits are don't-care
   task automatic set_block_count(input int value);
      drain();
      csr_write({REG_BLOCK_COUNT, 2'b00},
                {25'($urandom_range(32'h01FF_FFFF)), value[CFG_BITS-1:0]});
   endtask

   initial begin
      int counts [8];
      counts = '{64, 1, 127, 0, 2, 65, 33, 3};
      counts[7] = $urandom_range(3, 63);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: small table, size extremes, exact fit and miss
      set_block_count(4);
      send_req(OP_LOAD,  0, 16'hFFFF);
      send_req(OP_LOAD,  1, 16'h0000);
      send_req(OP_LOAD,  2, 16'h8000);
      send_req(OP_LOAD,  3, 16'h0001);
      send_req(OP_ALLOC, 0, 16'h0000);
      send_req(OP_ALLOC, 0, 16'hFFFF);
      send_req(OP_ALLOC, 0, 16'h0002);
      send_req(OP_ALLOC, 0, 16'h9000);
      send_req(OP_ALLOC, 0, 16'h7FFE);
      send_req(OP_LOAD,  63, 16'hFFFF);
      send_req(OP_LOAD,  3, 16'h5555);
      send_req(OP_ALLOC, 0, 16'h5555);
      send_req(OP_ALLOC, 0, 16'h0001);

      // pointer past a lowered count, then a zero count
      set_block_count(1);
      send_req(OP_ALLOC, 0, 16'h0001);
      set_block_count(0);
      send_req(OP_ALLOC, 0, 16'h0000);

      // fill the whole table; one large entry far from the pointer
      set_block_count(64);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_req(OP_LOAD, IDX_BITS'(i),
                  (i == 40) ? 16'hFFFF : PORT_SIZE_BITS'($urandom_range(15)));
      send_req(OP_ALLOC, 0, 16'h0100);
      set_block_count(8);
      send_req(OP_ALLOC, 0, 16'h0000);
      set_block_count(127);
      send_req(OP_ALLOC, 0, 16'h0200);

      // random phases over block counts and idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         set_block_count(counts[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         // long receiver hold-off while requests keep coming
         if (ph == 2 || ph == 4) begin
            @(posedge clock);
            hold_cycles = 400;
            @(negedge clock);
         end
         for (int i = 0; i < 225; i++)
            send_random();
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
